### design/spiral_order_cyclic_shift_map_core_assert.svh
// Assertion macros for the spiral order cyclic shift map core.
// Included by the design modules that carry concurrent checks.
`ifndef SPIRAL_ORDER_CYCLIC_SHIFT_MAP_CORE_ASSERT_SVH
`define SPIRAL_ORDER_CYCLIC_SHIFT_MAP_CORE_ASSERT_SVH

// same-cycle implication
`define SOCSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SOCSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/socsm_pkg.sv
// Shared constants, types and lookup functions for the spiral shift map.
// No dependencies; used by the interfaces and all design modules.
package socsm_pkg;

   localparam int MAX_SIZE  = 15;
   localparam int SIZE_W    = 4;
   localparam int DATA_W    = 32;
   localparam int SHIFT_W   = 8;
   localparam int CSR_W     = 8;
   localparam int CSR_IDX_W = 1;
   localparam int RING_W    = 3;
   localparam int POS_W     = 8;
   localparam int SUM_W     = 9;
   localparam int FRAC_W    = 16;
   localparam int RECIP_W   = FRAC_W + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam int DELTA_W   = 5;
   localparam int OFF_W     = 6;
   localparam int ARITH_W   = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_SIZE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_AMOUNT = 1'd1;

   localparam logic [SIZE_W-1:0]  MATRIX_SIZE_RST  = 4'd7;
   localparam logic [SHIFT_W-1:0] SHIFT_AMOUNT_RST = 8'd8;

   // first spiral position of ring k: (2k-1)^2 for k >= 1, and 0 for ring 0
   localparam logic [POS_W-1:0] RING_BASE [1 << RING_W] =
      '{8'd0, 8'd1, 8'd9, 8'd25, 8'd49, 8'd81, 8'd121, 8'd169};

   typedef logic signed [DELTA_W-1:0] delta_type;
   typedef logic signed [ARITH_W-1:0] arith_type;

   typedef struct packed {
      logic                     in_range;
      logic [SIZE_W-1:0]        src_row;
      logic [SIZE_W-1:0]        src_col;
      logic signed [DATA_W-1:0] value;
   } side_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
      logic [SIZE_W-1:0] s;
      s = raw;
      if (s > SIZE_W'(MAX_SIZE)) s = SIZE_W'(MAX_SIZE);
      if (s == '0) s = SIZE_W'(1);
      if (!s[0]) s = s - SIZE_W'(1);
      return s;
   endfunction

   function automatic logic [POS_W-1:0] cells_of(input logic [SIZE_W-1:0] n);
      logic [POS_W-1:0] w;
      w = POS_W'(n);
      return w * w;
   endfunction

   // floor(2^16 / n^2) for the odd sizes
   function automatic logic [RECIP_W-1:0] recip_of(input logic [SIZE_W-1:0] n);
      logic [RECIP_W-1:0] r;
      case (n)
         4'd3:    r = 17'd7281;
         4'd5:    r = 17'd2621;
         4'd7:    r = 17'd1337;
         4'd9:    r = 17'd809;
         4'd11:   r = 17'd541;
         4'd13:   r = 17'd387;
         4'd15:   r = 17'd291;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

endpackage

### design/socsm_req_if.sv
// Input item channel: one matrix element with its coordinates.
// Depends on socsm_pkg for field widths.
interface socsm_req_if;
   logic                              valid;
   logic                              ready;
   logic [socsm_pkg::SIZE_W-1:0]      src_row;
   logic [socsm_pkg::SIZE_W-1:0]      src_col;
   logic signed [socsm_pkg::DATA_W-1:0] elem_value;

   modport source (output valid, output src_row, output src_col, output elem_value,
                   input ready);
   modport sink   (input valid, input src_row, input src_col, input elem_value,
                   output ready);
endinterface

### design/socsm_rsp_if.sv
// Result item channel: destination coordinates and the carried value.
// Depends on socsm_pkg for field widths.
interface socsm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [socsm_pkg::SIZE_W-1:0]      dst_row;
   logic [socsm_pkg::SIZE_W-1:0]      dst_col;
   logic signed [socsm_pkg::DATA_W-1:0] moved_value;

   modport source (output valid, output dst_row, output dst_col, output moved_value,
                   input ready);
   modport sink   (input valid, input dst_row, input dst_col, input moved_value,
                   output ready);
endinterface

### design/spiral_order_cyclic_shift_map_core.sv
// Spiral order cyclic shift map: one result item per input item, seven pipeline
// stages, one item per cycle sustained while the output is not back-pressured. The
// stages are the center offset, ring and leg, spiral position plus shift, the modulo
// unit (reciprocal multiply, then product and fixup), ring lookup of the destination,
// and coordinate rebuild. Each stage holds its item until the next stage frees, so a
// stalled result costs no throughput until the pipeline fills. An element outside
// the effective matrix returns its own coordinates. Depends on socsm_pkg, the
// channel interfaces and socsm_wrap.
`include "spiral_order_cyclic_shift_map_core_assert.svh"

module spiral_order_cyclic_shift_map_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [socsm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [socsm_pkg::CSR_W-1:0]       csr_wdata,
   socsm_req_if.sink                         req_ch,
   socsm_rsp_if.source                       rsp_ch
);

   // configuration
   logic [socsm_pkg::SIZE_W-1:0]  matrix_size_ff;
   logic [socsm_pkg::SHIFT_W-1:0] shift_amount_ff;
   logic [socsm_pkg::SIZE_W-1:0]  n_eff;
   logic [socsm_pkg::SIZE_W-1:0]  center;
   logic [socsm_pkg::POS_W-1:0]   cells;
   logic [socsm_pkg::RECIP_W-1:0] recip;

   // stage enables
   logic a_en, b_en, c_en, e_en, f_en;
   logic w_in_ready, w_out_valid;

   // stage A: offsets from center
   logic                 a_v_ff;
   socsm_pkg::delta_type a_dx_ff, a_dy_ff, a_dx_in, a_dy_in;
   socsm_pkg::side_type  a_side_ff, a_side_in;

   // stage B: ring and offset along the ring
   logic                          b_v_ff;
   logic [socsm_pkg::RING_W-1:0]  b_k_ff, b_k_in;
   logic [socsm_pkg::OFF_W-1:0]   b_off_ff, b_off_in;
   socsm_pkg::side_type           b_side_ff;

   // stage C: shifted position
   logic                          c_v_ff;
   logic [socsm_pkg::SUM_W-1:0]   c_x_ff, c_x_in;
   socsm_pkg::side_type           c_side_ff;

   // modulo unit output
   logic [socsm_pkg::POS_W-1:0]   w_rem;
   socsm_pkg::side_type           w_side;

   // stage E: destination ring
   logic                          e_v_ff;
   logic [socsm_pkg::RING_W-1:0]  e_k_ff, e_k_in;
   logic [socsm_pkg::OFF_W-1:0]   e_off_ff, e_off_in;
   socsm_pkg::side_type           e_side_ff;

   // stage F: output register
   logic                             f_v_ff;
   logic [socsm_pkg::SIZE_W-1:0]     f_row_ff, f_row_in;
   logic [socsm_pkg::SIZE_W-1:0]     f_col_ff, f_col_in;
   logic signed [socsm_pkg::DATA_W-1:0] f_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_size_ff  <= socsm_pkg::MATRIX_SIZE_RST;
         shift_amount_ff <= socsm_pkg::SHIFT_AMOUNT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            socsm_pkg::CSR_MATRIX_SIZE:
               matrix_size_ff <= csr_wdata[socsm_pkg::SIZE_W-1:0];
            socsm_pkg::CSR_SHIFT_AMOUNT:
               shift_amount_ff <= csr_wdata[socsm_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   assign n_eff  = socsm_pkg::eff_size(matrix_size_ff);
   assign center = n_eff >> 1;
   assign cells  = socsm_pkg::cells_of(n_eff);
   assign recip  = socsm_pkg::recip_of(n_eff);

   // handshake chain
   assign f_en         = !f_v_ff || rsp_ch.ready;
   assign e_en         = !e_v_ff || f_en;
   assign c_en         = !c_v_ff || w_in_ready;
   assign b_en         = !b_v_ff || c_en;
   assign a_en         = !a_v_ff || b_en;
   assign req_ch.ready = a_en;

   // stage A
   always_comb begin
      a_dx_in = $signed({1'b0, req_ch.src_col}) - $signed({1'b0, center});
      a_dy_in = $signed({1'b0, req_ch.src_row}) - $signed({1'b0, center});
      a_side_in.in_range = (req_ch.src_row < n_eff) && (req_ch.src_col < n_eff);
      a_side_in.src_row  = req_ch.src_row;
      a_side_in.src_col  = req_ch.src_col;
      a_side_in.value    = req_ch.elem_value;
   end

   // stage B: legs are right side, top, left side, bottom
   always_comb begin
      logic [socsm_pkg::DELTA_W-1:0] adx, ady, kw;
      socsm_pkg::arith_type ks, dxs, dys, t;
      adx = a_dx_ff[socsm_pkg::DELTA_W-1] ? socsm_pkg::DELTA_W'(-a_dx_ff)
                                          : socsm_pkg::DELTA_W'(a_dx_ff);
      ady = a_dy_ff[socsm_pkg::DELTA_W-1] ? socsm_pkg::DELTA_W'(-a_dy_ff)
                                          : socsm_pkg::DELTA_W'(a_dy_ff);
      kw  = (adx > ady) ? adx : ady;
      b_k_in = socsm_pkg::RING_W'(kw);
      ks  = $signed({{(socsm_pkg::ARITH_W-socsm_pkg::RING_W){1'b0}}, b_k_in});
      dxs = socsm_pkg::arith_type'(a_dx_ff);
      dys = socsm_pkg::arith_type'(a_dy_ff);
      if (b_k_in == '0) begin
         t = '0;
      end else if (dxs == ks && dys < ks) begin
         t = ks - 8'sd1 - dys;
      end else if (dys == -ks && dxs < ks) begin
         t = ks * 8'sd3 - 8'sd1 - dxs;
      end else if (dxs == -ks) begin
         t = ks * 8'sd5 - 8'sd1 + dys;
      end else begin
         t = ks * 8'sd7 - 8'sd1 + dxs;
      end
      b_off_in = socsm_pkg::OFF_W'(t);
   end

   // stage C
   assign c_x_in = socsm_pkg::SUM_W'(socsm_pkg::RING_BASE[b_k_ff])
                 + socsm_pkg::SUM_W'(b_off_ff)
                 + socsm_pkg::SUM_W'(shift_amount_ff);

   socsm_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_v_ff),
      .in_ready  (w_in_ready),
      .in_x      (c_x_ff),
      .in_side   (c_side_ff),
      .cells     (cells),
      .recip     (recip),
      .out_valid (w_out_valid),
      .out_ready (e_en),
      .out_rem   (w_rem),
      .out_side  (w_side)
   );

   // stage E: ring count is the number of ring bases not above the position
   always_comb begin
      e_k_in = '0;
      for (int j = 1; j < (1 << socsm_pkg::RING_W); j++) begin
         e_k_in = e_k_in + socsm_pkg::RING_W'(w_rem >= socsm_pkg::RING_BASE[j]);
      end
      e_off_in = socsm_pkg::OFF_W'(w_rem - socsm_pkg::RING_BASE[e_k_in]);
   end

   // stage F
   always_comb begin
      socsm_pkg::arith_type ks, os, dx, dy, cs;
      ks = $signed({{(socsm_pkg::ARITH_W-socsm_pkg::RING_W){1'b0}}, e_k_ff});
      os = $signed({{(socsm_pkg::ARITH_W-socsm_pkg::OFF_W){1'b0}}, e_off_ff});
      cs = $signed({{(socsm_pkg::ARITH_W-socsm_pkg::SIZE_W){1'b0}}, center});
      if (e_k_ff == '0) begin
         dx = '0;
         dy = '0;
      end else if (os < ks * 8'sd2) begin
         dx = ks;
         dy = ks - 8'sd1 - os;
      end else if (os < ks * 8'sd4) begin
         dy = -ks;
         dx = ks * 8'sd3 - 8'sd1 - os;
      end else if (os < ks * 8'sd6) begin
         dx = -ks;
         dy = os - (ks * 8'sd5 - 8'sd1);
      end else begin
         dy = ks;
         dx = os - (ks * 8'sd7 - 8'sd1);
      end
      if (e_side_ff.in_range) begin
         f_row_in = socsm_pkg::SIZE_W'(cs + dy);
         f_col_in = socsm_pkg::SIZE_W'(cs + dx);
      end else begin
         f_row_in = e_side_ff.src_row;
         f_col_in = e_side_ff.src_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else begin
         if (a_en) a_v_ff <= req_ch.valid;
         if (b_en) b_v_ff <= a_v_ff;
         if (c_en) c_v_ff <= b_v_ff;
         if (e_en) e_v_ff <= w_out_valid;
         if (f_en) f_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_dx_ff   <= a_dx_in;
         a_dy_ff   <= a_dy_in;
         a_side_ff <= a_side_in;
      end
      if (b_en) begin
         b_k_ff    <= b_k_in;
         b_off_ff  <= b_off_in;
         b_side_ff <= a_side_ff;
      end
      if (c_en) begin
         c_x_ff    <= c_x_in;
         c_side_ff <= b_side_ff;
      end
      if (e_en) begin
         e_k_ff    <= e_k_in;
         e_off_ff  <= e_off_in;
         e_side_ff <= w_side;
      end
      if (f_en) begin
         f_row_ff   <= f_row_in;
         f_col_ff   <= f_col_in;
         f_value_ff <= e_side_ff.value;
      end
   end

   assign rsp_ch.valid       = f_v_ff;
   assign rsp_ch.dst_row     = f_row_ff;
   assign rsp_ch.dst_col     = f_col_ff;
   assign rsp_ch.moved_value = f_value_ff;

   `SOCSM_ASSERT_NOW(a_stall_from_output, clock, reset, !req_ch.ready, rsp_ch.valid && !rsp_ch.ready, "input stalled without output back-pressure")
   `SOCSM_ASSERT_NEXT(a_accept_fills_a, clock, reset, req_ch.valid && req_ch.ready, a_v_ff, "accepted item not captured")
   `SOCSM_ASSERT_NOW(a_ring_in_size, clock, reset, e_v_ff && e_side_ff.in_range, e_k_ff <= center, "destination ring outside matrix")
   `SOCSM_ASSERT_NOW(a_dst_in_matrix, clock, reset, f_v_ff && f_row_ff < n_eff && f_col_ff < n_eff, (rsp_ch.dst_row < n_eff) && (rsp_ch.dst_col < n_eff), "destination outside matrix")

endmodule

### design/socsm_wrap.sv
// Two-stage modulo unit: rem = x mod cells via reciprocal multiply and one fixup.
// Depends on socsm_pkg and the assertion macro header.
`include "spiral_order_cyclic_shift_map_core_assert.svh"

module socsm_wrap (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [socsm_pkg::SUM_W-1:0]     in_x,
   input  socsm_pkg::side_type             in_side,
   input  logic [socsm_pkg::POS_W-1:0]     cells,
   input  logic [socsm_pkg::RECIP_W-1:0]   recip,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [socsm_pkg::POS_W-1:0]     out_rem,
   output socsm_pkg::side_type             out_side
);

   logic                                       s1_en, s2_en;
   logic                                       s1_v_ff, s2_v_ff;
   logic [socsm_pkg::PROD_W-1:0]               s1_prod_ff, s1_prod_in;
   logic [socsm_pkg::SUM_W-1:0]                s1_x_ff;
   socsm_pkg::side_type                        s1_side_ff;
   logic [socsm_pkg::POS_W-1:0]                s2_rem_ff, s2_rem_in;
   socsm_pkg::side_type                        s2_side_ff;
   logic [socsm_pkg::SUM_W-1:0]                quot;
   logic [socsm_pkg::SUM_W+socsm_pkg::POS_W-1:0] qc;
   logic [socsm_pkg::SUM_W-1:0]                rem0;

   assign s2_en    = !s2_v_ff || out_ready;
   assign s1_en    = !s1_v_ff || s2_en;
   assign in_ready = s1_en;

   assign s1_prod_in = socsm_pkg::PROD_W'(in_x) * socsm_pkg::PROD_W'(recip);

   assign quot = s1_prod_ff[socsm_pkg::FRAC_W +: socsm_pkg::SUM_W];
   assign qc   = (socsm_pkg::SUM_W+socsm_pkg::POS_W)'(quot)
               * (socsm_pkg::SUM_W+socsm_pkg::POS_W)'(cells);
   assign rem0 = s1_x_ff - socsm_pkg::SUM_W'(qc);

   always_comb begin
      if (rem0 >= socsm_pkg::SUM_W'(cells)) begin
         s2_rem_in = socsm_pkg::POS_W'(rem0 - socsm_pkg::SUM_W'(cells));
      end else begin
         s2_rem_in = socsm_pkg::POS_W'(rem0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (s1_en) s1_v_ff <= in_valid;
         if (s2_en) s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_prod_ff <= s1_prod_in;
         s1_x_ff    <= in_x;
         s1_side_ff <= in_side;
      end
      if (s2_en) begin
         s2_rem_ff  <= s2_rem_in;
         s2_side_ff <= s1_side_ff;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_rem   = s2_rem_ff;
   assign out_side  = s2_side_ff;

   `SOCSM_ASSERT_NOW(a_rem_below_cells, clock, reset, out_valid, out_rem < cells, "remainder not below cell count")

endmodule
